// ----- hw/rtl/scfp_pkg.sv -----
// Shared types and constants of the serial command frame parser.
`default_nettype none

package scfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned KEY_W     = 3;
  // Payload bytes that a decoded event can draw on (time set is the longest).
  localparam int unsigned EVT_BYTES = 7;
  localparam int unsigned IN_DATA_W = 8;
  // tx_byte, coord_x, coord_y, key_code, year, month..second = 99 bits, padded.
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned PAD_W      = OUT_DATA_W - 99;
  // Beat index of the final reply byte; index 0 is the event beat.
  localparam logic [2:0]  LAST_BEAT  = 3'd5;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
  localparam logic [BYTE_W-1:0] REPLY_CODE  = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_TOUCH   = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_KEY     = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_TIME    = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_ACK     = 8'h05;
  localparam logic [BYTE_W-1:0] KEY_MAX     = 8'd5;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;

  typedef enum logic [KIND_W-1:0] {
    KIND_REPLY = 2'd0,
    KIND_TOUCH = 2'd1,
    KIND_KEY   = 2'd2,
    KIND_TIME  = 2'd3
  } kind_e;

  // Everything the result side needs from one good frame.
  typedef struct packed {
    kind_e                            ev;
    logic [BYTE_W-1:0]                cmd;
    logic [BYTE_W-1:0]                sum;
    logic [EVT_BYTES-1:0][BYTE_W-1:0] data;
  } frame_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scfp_parser.sv -----
// Input register, frame state machine and payload store.
`default_nettype none

module scfp_parser import scfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [TICK_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 in_func_i,
  input  wire logic [BYTE_W-1:0]    in_byte_i,
  input  wire logic                 free_i,
  output logic                      frame_valid_o,
  output frame_t                    frame_o
);

  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IdxW = $clog2(MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_PAYLOAD);

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } phase_e;

  logic              in_vld_q;
  logic              in_func_q;
  logic [BYTE_W-1:0] in_byte_q;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic [TICK_W-1:0] idle_q, idle_d;
  logic [TICK_W-1:0] timeout_q;
  logic [BYTE_W-1:0] store_q [MAX_PAYLOAD];

  logic              cmd_ok;
  logic              hit;
  logic              consume;
  logic              store_we;
  logic [TICK_W-1:0] idle_inc;
  logic [LenW-1:0]   cnt_inc;

  always_comb begin
    case (cmd_q)
      CMD_TOUCH: cmd_ok = (len_q == LenW'(4));
      CMD_KEY:   cmd_ok = (len_q == LenW'(1)) && (store_q[0] <= KEY_MAX);
      CMD_TIME:  cmd_ok = (len_q == LenW'(7));
      CMD_ACK:   cmd_ok = 1'b1;
      default:   cmd_ok = 1'b0;
    endcase
  end

  // A good checksum byte needs the result side free; every other beat passes.
  assign hit = in_vld_q && !in_func_q && (phase_q == PH_CHECK) &&
               (in_byte_q == sum_q) && cmd_ok;
  assign consume       = in_vld_q && (!hit || free_i);
  assign in_ready_o    = !in_vld_q || consume;
  assign frame_valid_o = hit && free_i;

  always_comb begin
    case (cmd_q)
      CMD_TOUCH: frame_o.ev = KIND_TOUCH;
      CMD_KEY:   frame_o.ev = KIND_KEY;
      CMD_TIME:  frame_o.ev = KIND_TIME;
      default:   frame_o.ev = KIND_REPLY;
    endcase
    frame_o.cmd = cmd_q;
    frame_o.sum = sum_q;
    for (int i = 0; i < EVT_BYTES; i++) begin
      frame_o.data[i] = store_q[i];
    end
  end

  assign idle_inc = (idle_q == {TICK_W{1'b1}}) ? idle_q : idle_q + 1'b1;
  assign cnt_inc  = cnt_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    sum_d    = sum_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    idle_d   = idle_q;
    store_we = 1'b0;
    if (consume) begin
      if (in_func_q) begin
        if (phase_q != PH_HUNT) begin
          // Drop a partial frame once the idle gap reaches the timeout.
          if (idle_inc >= timeout_q) begin
            phase_d = PH_HUNT;
            idle_d  = '0;
          end else begin
            idle_d  = idle_inc;
          end
        end
      end else begin
        idle_d = '0;
        case (phase_q)
          PH_HUNT: begin
            if (in_byte_q == SYNC_FIRST) phase_d = PH_SYNC2;
          end
          PH_SYNC2: begin
            if (in_byte_q == SYNC_SECOND) begin
              phase_d = PH_CMD;
            end else if (in_byte_q != SYNC_FIRST) begin
              phase_d = PH_HUNT;
            end
          end
          PH_CMD: begin
            cmd_d   = in_byte_q;
            sum_d   = in_byte_q;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if ((in_byte_q == '0) || (in_byte_q > MaxLen)) begin
              phase_d = PH_HUNT;
            end else begin
              len_d   = in_byte_q[LenW-1:0];
              cnt_d   = '0;
              sum_d   = sum_q + in_byte_q;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            store_we = 1'b1;
            sum_d    = sum_q + in_byte_q;
            cnt_d    = cnt_inc;
            if (cnt_inc >= len_q) phase_d = PH_CHECK;
          end
          PH_CHECK: begin
            phase_d = PH_HUNT;
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_HUNT;
      cmd_q     <= '0;
      sum_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      idle_q    <= '0;
      timeout_q <= TIMEOUT_RST;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (consume) begin
        in_vld_q <= 1'b0;
      end
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      idle_q  <= idle_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_func_q <= in_func_i;
      in_byte_q <= in_byte_i;
    end
    if (store_we) store_q[cnt_q[IdxW-1:0]] <= in_byte_q;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scfp_emitter.sv -----
// Result register: plays out the event beat (if the frame has one) and the five reply bytes.
`default_nettype none

module scfp_emitter import scfp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   frame_valid_i,
  input  wire frame_t                 frame_i,
  output logic                        free_o,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output logic [OUT_DATA_W-1:0]       m_data_o,
  output logic [KIND_W-1:0]           m_kind_o,
  output logic                        m_last_o
);

  logic        busy_q;
  logic [2:0]  idx_q;
  frame_t      frm_q;
  logic        beat_done;
  logic        at_last;
  logic [BYTE_W-1:0]  tx_byte;
  logic [15:0]        coord_x, coord_y, year;
  logic [KEY_W-1:0]   key_code;
  logic [BYTE_W-1:0]  month, day, hour, minute, second;
  kind_e              kind;

  assign at_last   = (idx_q == LAST_BEAT);
  assign beat_done = busy_q && m_ready_i;
  assign free_o    = !busy_q || (m_ready_i && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (frame_valid_i) begin
      busy_q <= 1'b1;
      // Skip the event beat for a reply-only command.
      idx_q  <= (frame_i.ev == KIND_REPLY) ? 3'd1 : 3'd0;
    end else if (beat_done) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_valid_i) frm_q <= frame_i;
  end

  always_comb begin
    kind     = KIND_REPLY;
    tx_byte  = '0;
    coord_x  = '0;
    coord_y  = '0;
    key_code = '0;
    year     = '0;
    month    = '0;
    day      = '0;
    hour     = '0;
    minute   = '0;
    second   = '0;
    case (idx_q)
      3'd0: begin
        kind = frm_q.ev;
        case (frm_q.ev)
          KIND_TOUCH: begin
            coord_x = {frm_q.data[0], frm_q.data[1]};
            coord_y = {frm_q.data[2], frm_q.data[3]};
          end
          KIND_KEY: begin
            key_code = frm_q.data[0][KEY_W-1:0];
          end
          KIND_TIME: begin
            year   = {frm_q.data[0], frm_q.data[1]};
            month  = frm_q.data[2];
            day    = frm_q.data[3];
            hour   = frm_q.data[4];
            minute = frm_q.data[5];
            second = frm_q.data[6];
          end
          default: begin
          end
        endcase
      end
      3'd1:    tx_byte = SYNC_FIRST;
      3'd2:    tx_byte = SYNC_SECOND;
      3'd3:    tx_byte = frm_q.cmd;
      3'd4:    tx_byte = REPLY_CODE;
      default: tx_byte = frm_q.sum;
    endcase
  end

  assign m_valid_o = busy_q;
  assign m_kind_o  = kind;
  assign m_last_o  = at_last;
  assign m_data_o  = {{PAD_W{1'b0}}, second, minute, hour, day, month, year,
                      key_code, coord_y, coord_x, tx_byte};

endmodule

`default_nettype wire

// ----- hw/rtl/serial_command_frame_parser_unit.sv -----
// Top level of the serial command frame parser.
`default_nettype none

// Takes one beat per cycle on the slave side (a closing byte can stall): a
// received UART byte (tuser 0) or timer tick (tuser 1). Beats are registered,
// then the frame state machine updates. A checksum byte that closes a valid
// frame yields 5 result beats (reply FF AA cmd 01 sum) or 6 (a touch, key or
// time event first), played out one per cycle from the result register while
// m_axis_tready is high, the first in the cycle after the closing byte is
// accepted. While those beats drain, other input beats keep flowing at one
// per cycle; only the next frame-closing byte waits for the result register.
// The user must write timeout_ticks through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block does not enforce it. It resets to 100.
module serial_command_frame_parser_unit import scfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [TICK_W-1:0]     cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                  s_axis_tuser,   // [0] func
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] tx_byte, [23:8] coord_x, [39:24] coord_y, [42:40] key_code,
  // [58:43] year, [66:59] month, [74:67] day, [82:75] hour,
  // [90:83] minute, [98:91] second, [103:99] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [KIND_W-1:0]          m_axis_tuser,   // [1:0] kind
  output logic                       m_axis_tlast    // last
);

  logic   free;
  logic   frame_valid;
  frame_t frame;

  scfp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .free_i       (free),
    .frame_valid_o(frame_valid),
    .frame_o      (frame)
  );

  scfp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(frame_valid),
    .frame_i      (frame),
    .free_o       (free),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_kind_o     (m_axis_tuser),
    .m_last_o     (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/scfp_checker.sv -----
// Port-level checks of the serial command frame parser, bound to the top level.
`default_nettype none

module scfp_checker import scfp_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [KIND_W-1:0]     m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // Hold a stalled beat.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // An event beat never closes a frame; the reply must follow at once.
  a_event_then_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser != KIND_REPLY) |=>
      m_axis_tvalid && (m_axis_tuser == KIND_REPLY) &&
      (m_axis_tdata[BYTE_W-1:0] == SYNC_FIRST))
    else $error("event beat not followed by reply header");

  a_event_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_REPLY) |-> !m_axis_tlast)
    else $error("event beat marked last");

  a_reply_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_REPLY) |->
      (m_axis_tdata[OUT_DATA_W-1:BYTE_W] == '0))
    else $error("reply beat carries event fields");

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
